// ----- src/psg_pkg.sv -----
`default_nettype none
package psg_pkg;

   localparam int CYCLES_PER_STEP = 16;
   localparam int NOISE_WIDTH     = 16;

   localparam int CHANNELS   = 4;
   localparam int TONE_CHANS = 3;
   localparam int NOISE_CHAN = 3;
   localparam int CHAN_W     = 2;

   localparam int DATA_W   = 8;
   localparam int CYCLES_W = 12;
   localparam int LEVEL_W  = 6;
   localparam int PERIOD_W = 10;
   localparam int COUNT_W  = 16;
   localparam int VOLUME_W = 4;

   // residue of the cycle accumulator and the step count that one request yields
   localparam int RESIDUE_W = (CYCLES_PER_STEP > 1) ? $clog2(CYCLES_PER_STEP) : 1;
   localparam int ACC_MAX   = (CYCLES_PER_STEP - 1) + ((1 << CYCLES_W) - 1);
   localparam int ACC_W     = $clog2(ACC_MAX + 1);
   localparam int STEPS_W   = $clog2(ACC_MAX / CYCLES_PER_STEP + 1);

   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   localparam logic [NOISE_WIDTH-1:0] NOISE_SEED = NOISE_WIDTH'(16'h8000);
   localparam logic [COUNT_W-1:0] NOISE_LIMIT_0 = COUNT_W'(16'h0010);
   localparam logic [COUNT_W-1:0] NOISE_LIMIT_1 = COUNT_W'(16'h0020);
   localparam logic [COUNT_W-1:0] NOISE_LIMIT_2 = COUNT_W'(16'h0040);

   localparam logic [1:0] NOISE_RATE_0    = 2'd0;
   localparam logic [1:0] NOISE_RATE_1    = 2'd1;
   localparam logic [1:0] NOISE_RATE_2    = 2'd2;
   localparam logic [1:0] NOISE_RATE_TONE = 2'd3;

   typedef enum logic [1:0] {
      KIND_LATCH = 2'd0,
      KIND_DATA  = 2'd1,
      KIND_CLOCK = 2'd2
   } request_kind_type;

   typedef struct packed {
      request_kind_type     kind;
      logic [DATA_W-1:0]    data_byte;
      logic [STEPS_W-1:0]   steps;
   } queue_entry_type;

endpackage
`default_nettype wire

// ----- src/psg_req_if.sv -----
`default_nettype none
interface psg_req_if;
   import psg_pkg::*;

   logic                valid;
   logic                ready;
   logic                req_type;
   logic [DATA_W-1:0]   data_byte;
   logic [CYCLES_W-1:0] cycles;

   modport source (output valid, output req_type, output data_byte, output cycles,
                   input ready);
   modport sink   (input valid, input req_type, input data_byte, input cycles,
                   output ready);
endinterface
`default_nettype wire

// ----- src/psg_rsp_if.sv -----
`default_nettype none
interface psg_rsp_if;
   import psg_pkg::*;

   logic               valid;
   logic               ready;
   logic [LEVEL_W-1:0] sample_level;

   modport source (output valid, output sample_level, input ready);
   modport sink   (input valid, input sample_level, output ready);
endinterface
`default_nettype wire

// ----- src/psg_front.sv -----
`default_nettype none
module psg_front (
   input  logic                      clock,
   input  logic                      reset,
   psg_req_if.sink                   req_bus,
   output logic                      push_valid,
   output psg_pkg::queue_entry_type  push_entry,
   input  logic                      push_ready
);
   import psg_pkg::*;

   logic [RESIDUE_W-1:0] residue_ff;
   logic [RESIDUE_W-1:0] residue_in;
   logic [ACC_W-1:0]     acc;
   logic                 accept;

   assign accept = req_bus.valid && push_ready;
   assign acc    = ACC_W'(residue_ff) + ACC_W'(req_bus.cycles);

   assign req_bus.ready = push_ready;
   assign push_valid    = req_bus.valid;

   always_comb begin
      if (req_bus.req_type) begin
         push_entry.kind = KIND_CLOCK;
      end else if (req_bus.data_byte[DATA_W-1]) begin
         push_entry.kind = KIND_LATCH;
      end else begin
         push_entry.kind = KIND_DATA;
      end
      push_entry.data_byte = req_bus.data_byte;
      push_entry.steps     = STEPS_W'(acc / CYCLES_PER_STEP);
   end

   // the residue only moves on clock requests; writes leave it alone
   always_comb begin
      residue_in = residue_ff;
      if (accept && req_bus.req_type) begin
         residue_in = RESIDUE_W'(acc % CYCLES_PER_STEP);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         residue_ff <= '0;
      end else begin
         residue_ff <= residue_in;
      end
   end

endmodule
`default_nettype wire

// ----- src/psg_queue.sv -----
`default_nettype none
module psg_queue (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      push_valid,
   input  psg_pkg::queue_entry_type  push_entry,
   output logic                      push_ready,
   output logic                      pop_valid,
   output psg_pkg::queue_entry_type  pop_entry,
   input  logic                      pop_ready
);
   import psg_pkg::*;

   queue_entry_type     slot_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0]   count_ff, count_in;
   logic                do_push;
   logic                do_pop;

   assign push_ready = (count_ff != QCNT_W'(QUEUE_DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign pop_entry  = slot_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule
`default_nettype wire

// ----- src/psg_back.sv -----
`default_nettype none
module psg_back (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      pop_valid,
   input  psg_pkg::queue_entry_type  pop_entry,
   output logic                      pop_ready,
   psg_rsp_if.source                 rsp_bus
);
   import psg_pkg::*;

   typedef enum logic [0:0] {
      ST_IDLE = 1'b0,
      ST_RUN  = 1'b1
   } state_type;

   state_type             state_ff, state_in;
   logic [STEPS_W-1:0]    steps_ff, steps_in;

   logic [PERIOD_W-1:0]   period_ff  [CHANNELS];
   logic [PERIOD_W-1:0]   period_in  [CHANNELS];
   logic [COUNT_W-1:0]    count_ff   [CHANNELS];
   logic [COUNT_W-1:0]    count_in   [CHANNELS];
   logic                  phase_ff   [CHANNELS];
   logic                  phase_in   [CHANNELS];
   logic [VOLUME_W-1:0]   volume_ff  [CHANNELS];
   logic [VOLUME_W-1:0]   volume_in  [CHANNELS];
   logic [NOISE_WIDTH-1:0] lfsr_ff, lfsr_in;
   logic [CHAN_W-1:0]     latch_chan_ff, latch_chan_in;
   logic                  latch_vol_ff, latch_vol_in;
   logic [LEVEL_W-1:0]    total_ff, total_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [LEVEL_W-1:0]    rsp_level_ff, rsp_level_in;

   // one generator step, computed from the current state
   logic [COUNT_W-1:0]    st_count [CHANNELS];
   logic                  st_phase [CHANNELS];
   logic [NOISE_WIDTH-1:0] st_lfsr;
   logic [LEVEL_W-1:0]    st_total;
   logic [COUNT_W-1:0]    noise_limit;
   logic [COUNT_W-1:0]    incr;
   logic                  fb;

   logic                  out_free;
   logic [CHAN_W-1:0]     wr_chan;
   logic                  wr_vol;

   assign out_free         = !rsp_valid_ff || rsp_bus.ready;
   assign rsp_bus.valid    = rsp_valid_ff;
   assign rsp_bus.sample_level = rsp_level_ff;
   assign pop_ready        = (state_ff == ST_IDLE);

   always_comb begin
      st_total = '0;
      for (int ch = 0; ch < TONE_CHANS; ch++) begin
         incr         = count_ff[ch] + 1'b1;
         st_count[ch] = incr;
         st_phase[ch] = phase_ff[ch];
         if (period_ff[ch] != '0 && incr >= COUNT_W'(period_ff[ch])) begin
            st_count[ch] = '0;
            st_phase[ch] = !phase_ff[ch];
         end
         if (st_phase[ch] || period_ff[ch] == PERIOD_W'(1)) begin
            st_total = st_total + LEVEL_W'(volume_ff[ch]);
         end
      end

      case (period_ff[NOISE_CHAN][1:0])
         NOISE_RATE_0: noise_limit = NOISE_LIMIT_0;
         NOISE_RATE_1: noise_limit = NOISE_LIMIT_1;
         NOISE_RATE_2: noise_limit = NOISE_LIMIT_2;
         default:      noise_limit = COUNT_W'(period_ff[NOISE_CHAN-1]);
      endcase

      incr                 = count_ff[NOISE_CHAN] + 1'b1;
      st_count[NOISE_CHAN] = incr;
      st_phase[NOISE_CHAN] = phase_ff[NOISE_CHAN];
      st_lfsr              = lfsr_ff;
      // white noise taps bits 0 and 3, periodic noise just rotates
      fb = period_ff[NOISE_CHAN][2] ? (lfsr_ff[0] ^ lfsr_ff[3]) : lfsr_ff[0];
      if (incr >= noise_limit) begin
         st_count[NOISE_CHAN] = '0;
         st_phase[NOISE_CHAN] = !phase_ff[NOISE_CHAN];
         if (!phase_ff[NOISE_CHAN]) begin
            st_lfsr = {fb, lfsr_ff[NOISE_WIDTH-1:1]};
         end
      end
      if (st_lfsr[0]) begin
         st_total = st_total + LEVEL_W'(volume_ff[NOISE_CHAN]);
      end
   end

   always_comb begin
      state_in      = state_ff;
      steps_in      = steps_ff;
      period_in     = period_ff;
      count_in      = count_ff;
      phase_in      = phase_ff;
      volume_in     = volume_ff;
      lfsr_in       = lfsr_ff;
      latch_chan_in = latch_chan_ff;
      latch_vol_in  = latch_vol_ff;
      total_in      = total_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_bus.ready;
      rsp_level_in  = rsp_level_ff;
      wr_chan       = latch_chan_ff;
      wr_vol        = latch_vol_ff;

      case (state_ff)
         ST_IDLE: begin
            if (pop_valid) begin
               case (pop_entry.kind)
                  KIND_LATCH: begin
                     wr_chan       = pop_entry.data_byte[6:5];
                     wr_vol        = pop_entry.data_byte[4];
                     latch_chan_in = wr_chan;
                     latch_vol_in  = wr_vol;
                     if (wr_vol) begin
                        volume_in[wr_chan] = ~pop_entry.data_byte[VOLUME_W-1:0];
                     end else begin
                        period_in[wr_chan] = {period_ff[wr_chan][PERIOD_W-1:4],
                                              pop_entry.data_byte[3:0]};
                     end
                  end
                  KIND_DATA: begin
                     if (wr_vol) begin
                        volume_in[wr_chan] = ~pop_entry.data_byte[VOLUME_W-1:0];
                     end else begin
                        period_in[wr_chan] = {pop_entry.data_byte[5:0],
                                              period_ff[wr_chan][3:0]};
                     end
                  end
                  KIND_CLOCK: begin
                     steps_in = pop_entry.steps;
                     state_in = ST_RUN;
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_RUN: begin
            if (steps_ff != '0) begin
               steps_in  = steps_ff - 1'b1;
               count_in  = st_count;
               phase_in  = st_phase;
               lfsr_in   = st_lfsr;
               total_in  = st_total;
            end else if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_level_in = total_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         steps_ff      <= '0;
         for (int ch = 0; ch < CHANNELS; ch++) begin
            period_ff[ch] <= '0;
            count_ff[ch]  <= '0;
            phase_ff[ch]  <= 1'b0;
            volume_ff[ch] <= '0;
         end
         lfsr_ff       <= NOISE_SEED;
         latch_chan_ff <= '0;
         latch_vol_ff  <= 1'b0;
         total_ff      <= '0;
         rsp_valid_ff  <= 1'b0;
         rsp_level_ff  <= '0;
      end else begin
         state_ff      <= state_in;
         steps_ff      <= steps_in;
         period_ff     <= period_in;
         count_ff      <= count_in;
         phase_ff      <= phase_in;
         volume_ff     <= volume_in;
         lfsr_ff       <= lfsr_in;
         latch_chan_ff <= latch_chan_in;
         latch_vol_ff  <= latch_vol_in;
         total_ff      <= total_in;
         rsp_valid_ff  <= rsp_valid_in;
         rsp_level_ff  <= rsp_level_in;
      end
   end

endmodule
`default_nettype wire

// ----- src/psg_tone_noise_generator_unit.sv -----
// Four-channel sound generator (three square-wave tones plus one LFSR noise channel).
// Requests are either register write bytes (req_type 0, latch/data byte format) or
// clock advances (req_type 1) of a cycle count; only clock requests return a
// response, the linear sum (0..60) of the volumes of the channels that are high.
// A front stage classifies each request and turns its cycle count into a number
// of generator steps (count plus carried remainder, divided by CYCLES_PER_STEP);
// a two-entry queue feeds the back end, which applies each write as it takes it from
// the queue and runs one generator step per clock. The back end's single step engine
// sets the rate. The response sits in an output register, so writes and the steps
// of the next clock request go on while a response waits for rsp_bus.ready; only a
// second finished response holds the back end, and the front then stalls once the
// queue is full.
// Reset is synchronous and leaves the noise register at 0x8000.
`default_nettype none
module psg_tone_noise_generator_unit (
   input  logic        clock,
   input  logic        reset,
   psg_req_if.sink     req_bus,
   psg_rsp_if.source   rsp_bus
);
   import psg_pkg::*;

   logic            push_valid;
   logic            push_ready;
   queue_entry_type push_entry;
   logic            pop_valid;
   logic            pop_ready;
   queue_entry_type pop_entry;

   psg_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_bus    (req_bus),
      .push_valid (push_valid),
      .push_entry (push_entry),
      .push_ready (push_ready)
   );

   psg_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_entry (push_entry),
      .push_ready (push_ready),
      .pop_valid  (pop_valid),
      .pop_entry  (pop_entry),
      .pop_ready  (pop_ready)
   );

   psg_back u_back (
      .clock      (clock),
      .reset      (reset),
      .pop_valid  (pop_valid),
      .pop_entry  (pop_entry),
      .pop_ready  (pop_ready),
      .rsp_bus    (rsp_bus)
   );

endmodule
`default_nettype wire
